// ===== hw/rtl/ftrd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Flow table retransmit detector package
// Shared constants and types for the front, queue and back stages.
// ----------------------------------------------------------------------------
package ftrd_pkg;

    localparam int FLOW_ENTRIES = 256;
    localparam int IDX_W = $clog2(FLOW_ENTRIES);
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

    localparam logic [7:0] FLAG_FIN = 8'h01;
    localparam logic [7:0] FLAG_SYN = 8'h02;
    localparam logic [7:0] FLAG_RST = 8'h04;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_TCP = 2'd1;
    localparam logic [1:0] KIND_UDP = 2'd2;

    typedef struct packed {
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] source_port;
        logic [15:0] dst_port;
        logic [1:0]  kind;
        logic        syn_fin;
        logic        any_ctl;
        logic signed [16:0] payload;
        logic [31:0] seq_number;
    } ftrd_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ftrd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Flow table front stage
// Accepts headers, classifies the protocol and computes the TCP payload.
// ----------------------------------------------------------------------------
module ftrd_front import ftrd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_src_address,
    input  wire logic [31:0] s_dst_address,
    input  wire logic [15:0] s_src_port,
    input  wire logic [15:0] s_dst_port,
    input  wire logic [7:0]  s_protocol,
    input  wire logic [15:0] s_ip_total_length,
    input  wire logic [3:0]  s_ip_header_words,
    input  wire logic [3:0]  s_tcp_header_words,
    input  wire logic [7:0]  s_tcp_flags,
    input  wire logic [31:0] s_seq_number,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output ftrd_cmd_t        cmd
);

    logic      valid_reg;
    ftrd_cmd_t cmd_reg;
    ftrd_cmd_t cmd_next;
    logic [6:0] hdr_bytes;

    assign s_ready = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd = cmd_reg;
    assign hdr_bytes = {({1'b0, s_ip_header_words} + {1'b0, s_tcp_header_words}), 2'b00};

    always_comb begin
        cmd_next.src_address = s_src_address;
        cmd_next.dst_address = s_dst_address;
        cmd_next.source_port = s_src_port;
        cmd_next.dst_port = s_dst_port;
        cmd_next.seq_number = s_seq_number;
        cmd_next.syn_fin = |(s_tcp_flags & (FLAG_SYN | FLAG_FIN));
        cmd_next.any_ctl = |(s_tcp_flags & (FLAG_SYN | FLAG_FIN | FLAG_RST));
        cmd_next.payload = '0;
        case (s_protocol)
            PROTO_TCP: begin
                cmd_next.kind = KIND_TCP;
                cmd_next.payload = $signed({1'b0, s_ip_total_length})
                    - $signed({10'd0, hdr_bytes});
            end
            PROTO_UDP: cmd_next.kind = KIND_UDP;
            default: cmd_next.kind = KIND_OTHER;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ftrd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Flow table command queue
// A two-entry queue between the front and back stages.
// ----------------------------------------------------------------------------
module ftrd_queue import ftrd_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire ftrd_cmd_t in_cmd,
    output logic           out_valid,
    input  wire logic      out_ready,
    output ftrd_cmd_t      out_cmd
);

    ftrd_cmd_t slot_reg [2];
    logic      wr_ptr_reg;
    logic      rd_ptr_reg;
    logic [1:0] count_reg;
    logic      push;
    logic      pop;

    assign in_ready = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_cmd = slot_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("Queue count out of range.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 2'd0 |-> !pop)
        else $error("Queue popped while empty.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("Queue pointers disagree with count.");

endmodule
`default_nettype wire

// ===== hw/rtl/ftrd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Flow table back stage
// Scans the flow memory entry by entry, reading and then comparing each, decides and appends flows.
// ----------------------------------------------------------------------------
module ftrd_back import ftrd_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire ftrd_cmd_t cmd,
    output logic           m_valid,
    input  wire logic      m_ready,
    output logic [1:0]     m_packet_kind,
    output logic           m_retransmitted,
    output logic           m_new_flow,
    output logic           m_table_full,
    output logic signed [16:0] m_payload_length,
    output logic [8:0]     m_tcp_flow_total,
    output logic [8:0]     m_udp_flow_total,
    output logic [31:0]    m_packets_seen
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    localparam int ENT_W = 32 + 32 + 16 + 16 + 1 + 32;

    logic [ENT_W-1:0] mem [FLOW_ENTRIES];
    logic [ENT_W-1:0] rd_data_reg;
    state_t state_reg;
    ftrd_cmd_t cur_reg;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] used_reg;
    logic [8:0] tcp_cnt_reg;
    logic [8:0] udp_cnt_reg;
    logic [31:0] pkt_cnt_reg;
    logic out_valid_reg;
    logic retx_reg;
    logic new_reg;
    logic full_reg;
    logic [1:0] kind_reg;
    logic signed [16:0] pay_reg;
    logic is_tcp;
    logic hit;
    logic [31:0] nxt;
    logic keep_alive;
    logic retx_now;
    logic wr_en;
    logic [ENT_W-1:0] wr_data;
    logic [31:0] seq_sum;

    assign is_tcp = cur_reg.kind == KIND_TCP;
    assign hit = rd_data_reg[ENT_W-1 -: 97] ==
        {cur_reg.src_address, cur_reg.dst_address, cur_reg.source_port,
         cur_reg.dst_port, is_tcp};
    assign nxt = rd_data_reg[31:0];
    assign keep_alive = (cur_reg.payload <= 17'sd1) && cur_reg.any_ctl
        && (cur_reg.seq_number + 32'd1 == nxt);
    assign retx_now = is_tcp && !keep_alive
        && ((cur_reg.payload > 17'sd0) || cur_reg.syn_fin) && (nxt > cur_reg.seq_number);
    assign seq_sum = cur_reg.seq_number + {{15{cur_reg.payload[16]}}, cur_reg.payload};
    assign wr_data = {cur_reg.src_address, cur_reg.dst_address, cur_reg.source_port,
        cur_reg.dst_port, is_tcp, is_tcp ? seq_sum : 32'd0};
    assign wr_en = state_reg == ST_CMP && scan_reg == used_reg
        && cur_reg.kind != KIND_OTHER && used_reg != CNT_W'(FLOW_ENTRIES);

    assign cmd_ready = state_reg == ST_IDLE && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_packet_kind = kind_reg;
    assign m_retransmitted = retx_reg;
    assign m_new_flow = new_reg;
    assign m_table_full = full_reg;
    assign m_payload_length = pay_reg;
    assign m_tcp_flow_total = tcp_cnt_reg;
    assign m_udp_flow_total = udp_cnt_reg;
    assign m_packets_seen = pkt_cnt_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[scan_reg[IDX_W-1:0]];
        if (wr_en) begin
            mem[used_reg[IDX_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
            tcp_cnt_reg <= '0;
            udp_cnt_reg <= '0;
            pkt_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            scan_reg <= '0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        cur_reg <= cmd;
                        scan_reg <= '0;
                        retx_reg <= 1'b0;
                        new_reg <= 1'b0;
                        full_reg <= 1'b0;
                        pkt_cnt_reg <= pkt_cnt_reg + 32'd1;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (cur_reg.kind == KIND_OTHER) begin
                        state_reg <= ST_DONE;
                    end else if (scan_reg != used_reg && hit) begin
                        retx_reg <= retx_now;
                        state_reg <= ST_DONE;
                    end else if (scan_reg == used_reg) begin
                        if (used_reg == CNT_W'(FLOW_ENTRIES)) begin
                            full_reg <= 1'b1;
                        end else begin
                            new_reg <= 1'b1;
                            used_reg <= used_reg + 1'b1;
                            if (is_tcp) begin
                                tcp_cnt_reg <= tcp_cnt_reg + 9'd1;
                            end else begin
                                udp_cnt_reg <= udp_cnt_reg + 9'd1;
                            end
                        end
                        state_reg <= ST_DONE;
                    end else begin
                        scan_reg <= scan_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE: begin
                    kind_reg <= cur_reg.kind;
                    pay_reg <= is_tcp ? cur_reg.payload : 17'sd0;
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(FLOW_ENTRIES))
        else $error("Flow count beyond table size.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CMP |-> scan_reg <= used_reg)
        else $error("Scan ran past stored flows.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> used_reg == $past(used_reg) + 1'b1)
        else $error("Append did not advance the flow count.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(new_reg && full_reg))
        else $error("New flow and full flag both set.");

endmodule
`default_nettype wire

// ===== hw/rtl/flow_table_retransmit_detector_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Flow table retransmit detector
// Five-tuple flow table with TCP retransmission detection.
// ----------------------------------------------------------------------------
// TCP and UDP commands scan the stored flows in the flow memory, reading and then comparing
// each entry, until a match or the end of the stored flows. The back stage takes a new command
// only after its last result is accepted; the front register and the queue hold headers meanwhile.
// Reset clears all counters and control state; flow memory contents are
// undefined until written, and entries beyond the stored count are never matched.
module flow_table_retransmit_detector_top import ftrd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_src_address,
    input  wire logic [31:0] s_dst_address,
    input  wire logic [15:0] s_src_port,
    input  wire logic [15:0] s_dst_port,
    input  wire logic [7:0]  s_protocol,
    input  wire logic [15:0] s_ip_total_length,
    input  wire logic [3:0]  s_ip_header_words,
    input  wire logic [3:0]  s_tcp_header_words,
    input  wire logic [7:0]  s_tcp_flags,
    input  wire logic [31:0] s_seq_number,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_packet_kind,
    output logic             m_retransmitted,
    output logic             m_new_flow,
    output logic             m_table_full,
    output logic signed [16:0] m_payload_length,
    output logic [8:0]       m_tcp_flow_total,
    output logic [8:0]       m_udp_flow_total,
    output logic [31:0]      m_packets_seen
);

    logic      f_valid;
    logic      f_ready;
    ftrd_cmd_t f_cmd;
    logic      q_valid;
    logic      q_ready;
    ftrd_cmd_t q_cmd;

    ftrd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_src_address(s_src_address), .s_dst_address(s_dst_address),
        .s_src_port(s_src_port), .s_dst_port(s_dst_port),
        .s_protocol(s_protocol), .s_ip_total_length(s_ip_total_length),
        .s_ip_header_words(s_ip_header_words), .s_tcp_header_words(s_tcp_header_words),
        .s_tcp_flags(s_tcp_flags), .s_seq_number(s_seq_number),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    ftrd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    ftrd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_packet_kind(m_packet_kind), .m_retransmitted(m_retransmitted),
        .m_new_flow(m_new_flow), .m_table_full(m_table_full),
        .m_payload_length(m_payload_length), .m_tcp_flow_total(m_tcp_flow_total),
        .m_udp_flow_total(m_udp_flow_total), .m_packets_seen(m_packets_seen)
    );

endmodule
`default_nettype wire
